// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the overlay shadow buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define OSDSB_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define OSDSB_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
  `OSDSB_ASSERT(lbl, clk_sig, rst_sig, !(cond), msg)

`endif

// ----- design/osdsb_pkg.sv -----
// Types and constants shared by the overlay shadow buffer modules.
package osdsb_pkg;

  // Fixed field widths.
  localparam int POS_W  = 15;
  localparam int RC_W   = 6;
  localparam int RUN_W  = 6;
  localparam int CELL_W = 10;

  // Longest run that one flush emits.
  localparam logic [RUN_W-1:0] MAX_RUN = 6'd60;

  // Input action codes.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  // Configuration register index (bit 2 of the byte address).
  localparam logic REG_BLANK = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_CLEAR,
    OP_FLUSH
  } op_t;

  typedef enum logic [2:0] {
    K_ACK,
    K_READ,
    K_RUN,
    K_DRAW,
    K_CLEAR
  } kind_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_WR_CMP,
    S_RD_DATA,
    S_SCAN_ISSUE,
    S_SCAN_CHK,
    S_RUN_LAST
  } back_state_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic             on_screen;
    logic [POS_W-1:0] pos;
    logic [8:0]       ch;
  } cmd_t;

endpackage

// ----- design/osdsb_if.sv -----
// Request and response channel interfaces of the overlay shadow buffer.
interface osdsb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] row;
  logic [7:0] col;
  logic [8:0] char_in;

  modport source (output valid, action, row, col, char_in, input ready);
  modport sink (input valid, action, row, col, char_in, output ready);
endinterface

interface osdsb_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [4:0] run_row;
  logic [5:0] run_col;
  logic       page_out;
  logic [8:0] char_value;
  logic       read_valid;
  logic       last;

  modport source (output valid, kind, run_row, run_col, page_out, char_value, read_valid,
                  last, input ready);
  modport sink (input valid, kind, run_row, run_col, page_out, char_value, read_valid,
                last, output ready);
endinterface

// ----- design/osdsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module osdsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/osdsb_front.sv -----
// Front end: accepts request words, computes the cell position and classifies them.
module osdsb_front import osdsb_pkg::*; #(
  parameter int SCREEN_ROWS = 22,
  parameter int SCREEN_COLS = 60
) (
  osdsb_req_if.sink req,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  localparam logic [POS_W-1:0] COLS_C  = POS_W'(SCREEN_COLS);
  localparam logic [POS_W-1:0] CELLS_C = POS_W'(SCREEN_ROWS * SCREEN_COLS);

  logic [POS_W-1:0] pos;

  // Linear position; a column past the row end spills into later rows.
  assign pos = (POS_W'(req.row) * COLS_C) + POS_W'(req.col);

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Classify the action and package the command.
  always_comb begin
    q_cmd.on_screen = pos < CELLS_C;
    q_cmd.pos       = pos;
    q_cmd.ch        = req.char_in;
    case (req.action)
      ACT_WRITE: q_cmd.op = OP_WRITE;
      ACT_READ:  q_cmd.op = OP_READ;
      ACT_CLEAR: q_cmd.op = OP_CLEAR;
      ACT_FLUSH: q_cmd.op = OP_FLUSH;
      default:   q_cmd.op = OP_FLUSH;
    endcase
  end

endmodule

// ----- design/osdsb_queue.sv -----
// Two-entry command queue between the front end and the back end.
module osdsb_queue import osdsb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_cmd   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- design/osdsb_back.sv -----
// Back end: executes commands on the cell memory and drives the response register.
module osdsb_back import osdsb_pkg::*; #(
  parameter int SCREEN_ROWS = 22,
  parameter int SCREEN_COLS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  input  logic [7:0]  blank_code,
  osdsb_rsp_if.source rsp
);

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [RC_W-1:0]   LAST_COL  = RC_W'(SCREEN_COLS - 1);

  back_state_t state, state_next;

  logic [ADDR_W-1:0] p, p_next;
  logic [RC_W-1:0]   prow, prow_next, pcol, pcol_next;
  logic [RC_W-1:0]   run_row, run_row_next, run_col, run_col_next;
  logic              run_page, run_page_next;
  logic [7:0]        cur_code, cur_code_next;
  logic [RUN_W-1:0]  run_n, run_n_next, n_new;
  logic              in_run, in_run_next;
  logic              draw_pending, draw_pending_next;
  logic              sweep_emit, sweep_emit_next;
  logic [ADDR_W-1:0] op_addr, op_addr_next;
  logic [8:0]        op_ch, op_ch_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic       d_dirty, d_page;
  logic [7:0] d_code;
  logic       grow, out_free;

  logic       emit, e_rv, e_last;
  kind_t      e_kind;
  logic [8:0] e_char;

  // Cell word layout: code, page, dirty.
  assign d_dirty  = ram_rdata[0];
  assign d_page   = ram_rdata[1];
  assign d_code   = ram_rdata[9:2];
  assign out_free = !rsp.valid || rsp.ready;
  assign n_new    = in_run ? run_n + RUN_W'(1) : RUN_W'(1);
  assign grow     = (pcol != LAST_COL) && (n_new < MAX_RUN);

  osdsb_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP: begin
        if (p == LAST_ADDR && (!sweep_emit || out_free)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          case (q_cmd.op)
            OP_WRITE: state_next = q_cmd.on_screen ? S_WR_CMP : S_IDLE;
            OP_READ:  state_next = q_cmd.on_screen ? S_RD_DATA : S_IDLE;
            OP_CLEAR: state_next = S_SWEEP;
            OP_FLUSH: state_next = S_SCAN_ISSUE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_WR_CMP, S_RD_DATA, S_RUN_LAST: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_ISSUE: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (out_free) begin
          if (!in_run) begin
            if (d_dirty) begin
              state_next = grow ? S_SCAN_ISSUE : S_RUN_LAST;
            end else if (p == LAST_ADDR) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN_ISSUE;
            end
          end else if (d_dirty && d_page == run_page) begin
            state_next = grow ? S_SCAN_ISSUE : S_RUN_LAST;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control, result generation and datapath updates.
  always_comb begin
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = p;
    ram_wdata         = {cur_code, run_page, 1'b0};
    ram_re            = 1'b0;
    ram_raddr         = p;
    emit              = 1'b0;
    e_kind            = K_ACK;
    e_char            = 9'd0;
    e_rv              = 1'b0;
    e_last            = 1'b1;
    p_next            = p;
    prow_next         = prow;
    pcol_next         = pcol;
    run_row_next      = run_row;
    run_col_next      = run_col;
    run_page_next     = run_page;
    cur_code_next     = cur_code;
    run_n_next        = run_n;
    in_run_next       = in_run;
    draw_pending_next = draw_pending;
    sweep_emit_next   = sweep_emit;
    op_addr_next      = op_addr;
    op_ch_next        = op_ch;
    case (state)
      S_SWEEP: begin
        // Blank one cell per cycle.
        ram_we    = 1'b1;
        ram_wdata = {blank_code, 1'b0, 1'b0};
        if (p != LAST_ADDR) begin
          p_next = p + ADDR_W'(1);
        end else if (sweep_emit && out_free) begin
          emit              = 1'b1;
          e_kind            = K_CLEAR;
          draw_pending_next = 1'b1;
          sweep_emit_next   = 1'b0;
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop        = 1'b1;
          op_addr_next = q_cmd.pos[ADDR_W-1:0];
          op_ch_next   = q_cmd.ch;
          ram_raddr    = q_cmd.pos[ADDR_W-1:0];
          p_next       = '0;
          prow_next    = '0;
          pcol_next    = '0;
          in_run_next  = 1'b0;
          case (q_cmd.op)
            OP_WRITE: begin
              ram_re = q_cmd.on_screen;
              emit   = !q_cmd.on_screen;
            end
            OP_READ: begin
              ram_re = q_cmd.on_screen;
              emit   = !q_cmd.on_screen;
              e_kind = K_READ;
            end
            OP_CLEAR: sweep_emit_next = 1'b1;
            default: ;
          endcase
        end
      end
      S_WR_CMP: begin
        // Store and mark dirty only on a change of code or page.
        if (out_free) begin
          emit      = 1'b1;
          ram_waddr = op_addr;
          ram_wdata = {op_ch[7:0], op_ch[8], 1'b1};
          ram_we    = (d_code != op_ch[7:0]) || (d_page != op_ch[8]);
        end
      end
      S_RD_DATA: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = K_READ;
          e_char = {d_page, d_code};
          e_rv   = 1'b1;
        end
      end
      S_SCAN_ISSUE: ram_re = 1'b1;
      S_SCAN_CHK: begin
        if (out_free) begin
          if (in_run && !(d_dirty && d_page == run_page)) begin
            // Run ends before this cell.
            emit              = 1'b1;
            e_kind            = K_RUN;
            e_char            = {1'b0, cur_code};
            draw_pending_next = 1'b1;
          end else if (d_dirty) begin
            // Take this cell into the run and clear its dirty bit.
            if (in_run) begin
              emit   = 1'b1;
              e_kind = K_RUN;
              e_char = {1'b0, cur_code};
              e_last = 1'b0;
            end else begin
              run_row_next  = prow;
              run_col_next  = pcol;
              run_page_next = d_page;
            end
            in_run_next   = 1'b1;
            run_n_next    = n_new;
            cur_code_next = d_code;
            ram_we        = 1'b1;
            ram_wdata     = {d_code, d_page, 1'b0};
          end else if (p == LAST_ADDR) begin
            // Nothing dirty left: issue the pending draw or an ack.
            emit = 1'b1;
            if (draw_pending) begin
              e_kind            = K_DRAW;
              draw_pending_next = 1'b0;
            end
          end
          if ((!in_run && !d_dirty && p != LAST_ADDR) || (d_dirty && grow &&
              (!in_run || d_page == run_page))) begin
            p_next = p + ADDR_W'(1);
            if (pcol == LAST_COL) begin
              pcol_next = '0;
              prow_next = prow + RC_W'(1);
            end else begin
              pcol_next = pcol + RC_W'(1);
            end
          end
        end
      end
      S_RUN_LAST: begin
        if (out_free) begin
          emit              = 1'b1;
          e_kind            = K_RUN;
          e_char            = {1'b0, cur_code};
          draw_pending_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      p            <= '0;
      in_run       <= 1'b0;
      draw_pending <= 1'b0;
      sweep_emit   <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      state        <= state_next;
      p            <= p_next;
      in_run       <= in_run_next;
      draw_pending <= draw_pending_next;
      sweep_emit   <= sweep_emit_next;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath and response payload registers.
  always_ff @(posedge clk) begin
    prow     <= prow_next;
    pcol     <= pcol_next;
    run_row  <= run_row_next;
    run_col  <= run_col_next;
    run_page <= run_page_next;
    cur_code <= cur_code_next;
    run_n    <= run_n_next;
    op_addr  <= op_addr_next;
    op_ch    <= op_ch_next;
    if (emit) begin
      rsp.kind       <= e_kind;
      rsp.run_row    <= (e_kind == K_RUN) ? run_row[4:0] : 5'd0;
      rsp.run_col    <= (e_kind == K_RUN) ? run_col : 6'd0;
      rsp.page_out   <= (e_kind == K_RUN) && run_page;
      rsp.char_value <= e_char;
      rsp.read_valid <= e_rv;
      rsp.last       <= e_last;
    end
  end

endmodule

// ----- design/osd_shadow_buffer_dirty_runs_unit.sv -----
// Top level of the overlay shadow buffer with dirty-run flushing.
// Character overlay shadow screen of SCREEN_ROWS by SCREEN_COLS cells, each cell holding a code,
// a font page bit and a dirty bit in one single-port-write, registered-read memory. A front end
// turns each request word into a command in a two-entry queue; a back end sequencer carries it
// out on the memory. A write reads the cell, compares it and writes it only on a change of code
// or page; a read returns the stored cell; an off-screen access is answered without touching
// the memory. A clear sweeps the memory one cell per cycle; the same sweep runs after reset,
// and no request is executed during it (configuration writes are taken). A flush reads and
// checks one cell at a time (issue, then check) from the first cell to the start of the first
// dirty run and then along the run. Response words are held in an output register. blank_code
// sits at APB byte address 0.
module osd_shadow_buffer_dirty_runs_unit import osdsb_pkg::*; #(
  parameter int SCREEN_ROWS = 22,
  parameter int SCREEN_COLS = 60
) (
  input  logic        clk,
  input  logic        rst,
  osdsb_req_if.sink   req,
  osdsb_rsp_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] blank_code;
  logic       q_push, q_full, q_pop, q_valid;
  cmd_t       push_cmd, head_cmd;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLANK) ? {24'd0, blank_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_code <= 8'd32;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLANK) begin
      blank_code <= pwdata[7:0];
    end
  end

  osdsb_front #(.SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS)) u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  osdsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  osdsb_back #(.SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .blank_code (blank_code),
    .rsp        (rsp)
  );

endmodule

// ----- design/osdsb_checker.sv -----
// Port-level checker of the overlay shadow buffer and its bind to the top level.
`include "assert_macros.svh"

module osdsb_checker import osdsb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] kind,
  input logic [4:0] run_row,
  input logic [5:0] run_col,
  input logic       page_out,
  input logic [8:0] char_value,
  input logic       read_valid,
  input logic       last
);

  `OSDSB_ASSERT(a_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(char_value) && $stable(last), "stalled response word changed")
  `OSDSB_NEVER(a_kind, clk, rst, rsp_valid && kind > 3'(K_CLEAR), "response kind out of range")
  `OSDSB_NEVER(a_norun, clk, rst, rsp_valid && kind != 3'(K_RUN) && (run_row != 5'd0 || run_col != 6'd0 || page_out), "run fields set outside a run word")
  `OSDSB_ASSERT(a_single, clk, rst, rsp_valid && (kind == 3'(K_ACK) || kind == 3'(K_DRAW) || kind == 3'(K_CLEAR)) |-> last && char_value == 9'd0 && !read_valid, "single word response malformed")

endmodule

bind osd_shadow_buffer_dirty_runs_unit osdsb_checker u_osdsb_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .kind       (rsp.kind),
  .run_row    (rsp.run_row),
  .run_col    (rsp.run_col),
  .page_out   (rsp.page_out),
  .char_value (rsp.char_value),
  .read_valid (rsp.read_valid),
  .last       (rsp.last)
);
